@@ src/nmeafe_pkg.sv @@
`default_nettype none
package nmeafe_pkg;

   // Result type codes
   typedef enum logic [1:0] {
      TYPE_NONE = 2'd0,
      TYPE_GLL  = 2'd1,
      TYPE_GSV  = 2'd2,
      TYPE_RMC  = 2'd3
   } sentence_code_type;

   // Bit positions in the type-seen flags
   localparam int unsigned FLAG_GLL = 0;
   localparam int unsigned FLAG_GSV = 1;
   localparam int unsigned FLAG_RMC = 2;

   // Characters and substrings watched for
   localparam logic [7:0]  CHAR_COMMA = 8'h2C;
   localparam logic [7:0]  CHAR_ZERO  = 8'h30;
   localparam logic [7:0]  CHAR_NINE  = 8'h39;
   localparam logic [23:0] CODE_GLL   = 24'h474C4C;
   localparam logic [23:0] CODE_GSV   = 24'h475356;
   localparam logic [23:0] CODE_RMC   = 24'h524D43;

   // Text capture limits
   localparam int unsigned TEXT_CHARS    = 8;
   localparam int unsigned TIME_CHARS    = 6;
   localparam int unsigned GLL_LAT_CHARS = 7;
   localparam logic [2:0]  LAST_FIELD    = 3'd7;
   localparam logic [3:0]  LAST_POS      = 4'd15;
   localparam logic [7:0]  NUMBER_MAX    = 8'd255;

   // Per-sentence capture state
   typedef struct packed {
      logic [2:0]  field_index;
      logic [3:0]  char_in_field;
      logic [23:0] recent_chars;
      logic [2:0]  type_seen_flags;
      logic [63:0] field_one_text;
      logic [7:0]  field_two_char;
      logic [63:0] field_three_text;
      logic [7:0]  field_three_number;
      logic        digit_run_over;
      logic [7:0]  field_four_char;
      logic [63:0] field_five_text;
      logic [7:0]  field_six_char;
   } sentence_state_type;

   // One result transaction
   typedef struct packed {
      sentence_code_type sentence_type;
      logic [47:0]       fix_time_text;
      logic [7:0]        fix_status_char;
      logic [63:0]       latitude_text;
      logic [7:0]        latitude_hemisphere;
      logic [63:0]       longitude_text;
      logic [7:0]        longitude_hemisphere;
      logic [7:0]        satellites_in_view;
   } result_type;

endpackage
`default_nettype wire

@@ src/nmeafe_result_format.sv @@
`default_nettype none
module nmeafe_result_format (
   input  nmeafe_pkg::sentence_state_type state,
   output nmeafe_pkg::result_type         result
);
   import nmeafe_pkg::*;

   localparam int unsigned TIME_DROP = 8 * (TEXT_CHARS - TIME_CHARS);
   localparam int unsigned LAT_DROP  = 8 * (TEXT_CHARS - GLL_LAT_CHARS);

   // Pick the fields by type, GLL first, then GSV, then RMC
   always_comb begin
      result = '0;
      result.sentence_type = TYPE_NONE;
      if (state.type_seen_flags[FLAG_GLL]) begin
         result.sentence_type        = TYPE_GLL;
         result.latitude_text        = {state.field_one_text[63:LAT_DROP], LAT_DROP'(0)};
         result.latitude_hemisphere  = state.field_two_char;
         result.longitude_text       = state.field_three_text;
         result.longitude_hemisphere = state.field_four_char;
      end else if (state.type_seen_flags[FLAG_GSV]) begin
         result.sentence_type      = TYPE_GSV;
         result.satellites_in_view = state.field_three_number;
      end else if (state.type_seen_flags[FLAG_RMC]) begin
         result.sentence_type        = TYPE_RMC;
         result.fix_time_text        = state.field_one_text[63:TIME_DROP];
         result.fix_status_char      = state.field_two_char;
         result.latitude_text        = state.field_three_text;
         result.latitude_hemisphere  = state.field_four_char;
         result.longitude_text       = state.field_five_text;
         result.longitude_hemisphere = state.field_six_char;
      end
   end

endmodule
`default_nettype wire

@@ src/nmea_sentence_field_extractor_core.sv @@
// The result of a sentence is registered and appears in the cycle after its last character is accepted.
// Throughput: one character per cycle while req_stall is low; the field counter and byte capture update together.
// req_stall is high only while a finished result is held and rsp_stall is high.
// Reset (synchronous, active high) clears the sentence state and the result valid.
`default_nettype none
module nmea_sentence_field_extractor_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_char_code,
   input  wire logic        req_end_of_sentence,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_sentence_type,
   output logic [47:0]      rsp_fix_time_text,
   output logic [7:0]       rsp_fix_status_char,
   output logic [63:0]      rsp_latitude_text,
   output logic [7:0]       rsp_latitude_hemisphere,
   output logic [63:0]      rsp_longitude_text,
   output logic [7:0]       rsp_longitude_hemisphere,
   output logic [7:0]       rsp_satellites_in_view
);
   import nmeafe_pkg::*;

   sentence_state_type sent_ff, sent_in, taken;
   result_type         result, rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               accept;
   logic [11:0]        number_sum;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   // Take one character into the sentence state
   always_comb begin
      taken = sent_ff;
      number_sum = 12'(sent_ff.field_three_number) * 12'd10 + 12'(req_char_code[3:0]);
      taken.recent_chars = {sent_ff.recent_chars[15:0], req_char_code};
      if (taken.recent_chars == CODE_GLL) taken.type_seen_flags[FLAG_GLL] = 1'b1;
      if (taken.recent_chars == CODE_GSV) taken.type_seen_flags[FLAG_GSV] = 1'b1;
      if (taken.recent_chars == CODE_RMC) taken.type_seen_flags[FLAG_RMC] = 1'b1;
      if (req_char_code == CHAR_COMMA) begin
         if (sent_ff.field_index != LAST_FIELD) taken.field_index = sent_ff.field_index + 3'd1;
         taken.char_in_field = '0;
      end else begin
         case (sent_ff.field_index)
            3'd1: begin
               for (int i = 0; i < TEXT_CHARS; i++) begin
                  if (!sent_ff.char_in_field[3] && sent_ff.char_in_field[2:0] == 3'(7 - i))
                     taken.field_one_text[i*8 +: 8] = sent_ff.field_one_text[i*8 +: 8]
                                                      | req_char_code;
               end
            end
            3'd2: begin
               if (sent_ff.char_in_field == 4'd0) taken.field_two_char = req_char_code;
            end
            3'd3: begin
               for (int i = 0; i < TEXT_CHARS; i++) begin
                  if (!sent_ff.char_in_field[3] && sent_ff.char_in_field[2:0] == 3'(7 - i))
                     taken.field_three_text[i*8 +: 8] = sent_ff.field_three_text[i*8 +: 8]
                                                        | req_char_code;
               end
               if (!sent_ff.digit_run_over) begin
                  if (req_char_code inside {[CHAR_ZERO:CHAR_NINE]}) begin
                     taken.field_three_number = (number_sum > 12'(NUMBER_MAX)) ?
                                                NUMBER_MAX : number_sum[7:0];
                  end else begin
                     taken.digit_run_over = 1'b1;
                  end
               end
            end
            3'd4: begin
               if (sent_ff.char_in_field == 4'd0) taken.field_four_char = req_char_code;
            end
            3'd5: begin
               for (int i = 0; i < TEXT_CHARS; i++) begin
                  if (!sent_ff.char_in_field[3] && sent_ff.char_in_field[2:0] == 3'(7 - i))
                     taken.field_five_text[i*8 +: 8] = sent_ff.field_five_text[i*8 +: 8]
                                                       | req_char_code;
               end
            end
            3'd6: begin
               if (sent_ff.char_in_field == 4'd0) taken.field_six_char = req_char_code;
            end
            default: begin
            end
         endcase
         if (sent_ff.char_in_field != LAST_POS)
            taken.char_in_field = sent_ff.char_in_field + 4'd1;
      end
   end

   nmeafe_result_format u_format (
      .state  (taken),
      .result (result)
   );

   // Next state: clear after the last character, hold when nothing is accepted
   always_comb begin
      sent_in      = sent_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (accept) begin
         if (req_end_of_sentence) begin
            sent_in      = '0;
            rsp_in       = result;
            rsp_valid_in = 1'b1;
         end else begin
            sent_in = taken;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sent_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sent_ff      <= sent_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_sentence_type        = rsp_ff.sentence_type;
   assign rsp_fix_time_text        = rsp_ff.fix_time_text;
   assign rsp_fix_status_char      = rsp_ff.fix_status_char;
   assign rsp_latitude_text        = rsp_ff.latitude_text;
   assign rsp_latitude_hemisphere  = rsp_ff.latitude_hemisphere;
   assign rsp_longitude_text       = rsp_ff.longitude_text;
   assign rsp_longitude_hemisphere = rsp_ff.longitude_hemisphere;
   assign rsp_satellites_in_view   = rsp_ff.satellites_in_view;

endmodule
`default_nettype wire

@@ src/nmeafe_checker.sv @@
`default_nettype none
module nmeafe_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        req_end_of_sentence,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [1:0]  rsp_sentence_type,
   input wire logic [47:0] rsp_fix_time_text,
   input wire logic [7:0]  rsp_fix_status_char,
   input wire logic [63:0] rsp_latitude_text,
   input wire logic [7:0]  rsp_latitude_hemisphere,
   input wire logic [63:0] rsp_longitude_text,
   input wire logic [7:0]  rsp_longitude_hemisphere,
   input wire logic [7:0]  rsp_satellites_in_view
);
   import nmeafe_pkg::*;

   // No result right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A held result stays with its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sentence_type)
                                && $stable(rsp_fix_time_text)
                                && $stable(rsp_fix_status_char)
                                && $stable(rsp_latitude_text)
                                && $stable(rsp_latitude_hemisphere)
                                && $stable(rsp_longitude_text)
                                && $stable(rsp_longitude_hemisphere)
                                && $stable(rsp_satellites_in_view))
      else $error("stalled result changed");

   // Input is held off while a result waits
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input taken while result is held");

   // A result only follows the last character of a sentence
   assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && rsp_stall) && !(req_valid && !req_stall && req_end_of_sentence)
      |=> !rsp_valid)
      else $error("result without end of sentence");

   // Satellite count only for GSV, time only for RMC
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_sentence_type == TYPE_GSV || rsp_satellites_in_view == 8'd0)
                 && (rsp_sentence_type == TYPE_RMC || rsp_fix_time_text == 48'd0))
      else $error("field set for wrong sentence type");

endmodule

bind nmea_sentence_field_extractor_core nmeafe_checker u_nmeafe_checker (.*);
`default_nettype wire

@@ sim/nmea_sentence_field_extractor_core_test.sv @@
`timescale 1ns / 100ps

module nmea_sentence_field_extractor_core_test;
   import nmeafe_pkg::*;

   localparam int unsigned RANDOM_CHARS    = 1450;
   localparam int unsigned HOLD_OFF_CYCLES = 300;
   localparam int unsigned WATCHDOG_LIMIT  = 3000;
   localparam int unsigned DRAIN_CYCLES    = 4;
   localparam int unsigned PRINT_LIMIT     = 50;

   // one character transaction on the request side
   typedef struct packed {
      logic [7:0] code;
      logic       last;
   } nmea_char_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_char_code = 8'h00;
   logic        req_end_of_sentence = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_sentence_type;
   logic [47:0] rsp_fix_time_text;
   logic [7:0]  rsp_fix_status_char;
   logic [63:0] rsp_latitude_text;
   logic [7:0]  rsp_latitude_hemisphere;
   logic [63:0] rsp_longitude_text;
   logic [7:0]  rsp_longitude_hemisphere;
   logic [7:0]  rsp_satellites_in_view;

   nmea_char_type      char_backlog[$];
   result_type         awaited_results[$];
   sentence_state_type sentence_acc = '0;
   int unsigned        chars_queued = 0;
   int unsigned        chars_accepted = 0;
   int unsigned        results_seen = 0;
   int unsigned        errors = 0;
   int unsigned        idle_cycles = 0;

   nmea_sentence_field_extractor_core u_dut (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_stall                (req_stall),
      .req_char_code            (req_char_code),
      .req_end_of_sentence      (req_end_of_sentence),
      .rsp_valid                (rsp_valid),
      .rsp_stall                (rsp_stall),
      .rsp_sentence_type        (rsp_sentence_type),
      .rsp_fix_time_text        (rsp_fix_time_text),
      .rsp_fix_status_char      (rsp_fix_status_char),
      .rsp_latitude_text        (rsp_latitude_text),
      .rsp_latitude_hemisphere  (rsp_latitude_hemisphere),
      .rsp_longitude_text       (rsp_longitude_text),
      .rsp_longitude_hemisphere (rsp_longitude_hemisphere),
      .rsp_satellites_in_view   (rsp_satellites_in_view)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // left-aligned text capture: char pos lands in byte 7-pos, past eight chars dropped
   function automatic logic [63:0] place_char(input logic [63:0] text, input logic [3:0] pos,
                                              input logic [7:0] ch);
      if (pos >= TEXT_CHARS) return text;
      return text | ({56'd0, ch} << (8 * (TEXT_CHARS - 1 - pos)));
   endfunction

   // sentence decoder: folds one character into the running sentence state,
   // returns 1 with the decoded fields on the last character
   function automatic bit fold_char(input logic [7:0] ch, input logic last,
                                    output result_type res);
      logic [3:0]  pos;
      int unsigned acc;
      pos = sentence_acc.char_in_field;
      res = '0;

      // substring watch over the last three characters
      sentence_acc.recent_chars = {sentence_acc.recent_chars[15:0], ch};
      if (sentence_acc.recent_chars == CODE_GLL) sentence_acc.type_seen_flags[FLAG_GLL] = 1'b1;
      if (sentence_acc.recent_chars == CODE_GSV) sentence_acc.type_seen_flags[FLAG_GSV] = 1'b1;
      if (sentence_acc.recent_chars == CODE_RMC) sentence_acc.type_seen_flags[FLAG_RMC] = 1'b1;

      if (ch == CHAR_COMMA) begin
         if (sentence_acc.field_index != LAST_FIELD) sentence_acc.field_index++;
         sentence_acc.char_in_field = '0;
      end else begin
         case (sentence_acc.field_index)
            3'd1: sentence_acc.field_one_text = place_char(sentence_acc.field_one_text, pos, ch);
            3'd2: if (pos == 0) sentence_acc.field_two_char = ch;
            3'd3: begin
               sentence_acc.field_three_text = place_char(sentence_acc.field_three_text, pos, ch);
               // decimal run from field start, saturating
               if (!sentence_acc.digit_run_over) begin
                  if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
                     acc = sentence_acc.field_three_number * 10 + (ch - CHAR_ZERO);
                     sentence_acc.field_three_number = (acc > NUMBER_MAX) ? NUMBER_MAX : acc[7:0];
                  end else begin
                     sentence_acc.digit_run_over = 1'b1;
                  end
               end
            end
            3'd4: if (pos == 0) sentence_acc.field_four_char = ch;
            3'd5: sentence_acc.field_five_text = place_char(sentence_acc.field_five_text, pos, ch);
            3'd6: if (pos == 0) sentence_acc.field_six_char = ch;
            default: ;
         endcase
         if (sentence_acc.char_in_field != LAST_POS) sentence_acc.char_in_field++;
      end

      if (!last) return 1'b0;

      // type priority GLL > GSV > RMC
      if (sentence_acc.type_seen_flags[FLAG_GLL]) begin
         res.sentence_type        = TYPE_GLL;
         res.latitude_text        = {sentence_acc.field_one_text[63:8], 8'h00};
         res.latitude_hemisphere  = sentence_acc.field_two_char;
         res.longitude_text       = sentence_acc.field_three_text;
         res.longitude_hemisphere = sentence_acc.field_four_char;
      end else if (sentence_acc.type_seen_flags[FLAG_GSV]) begin
         res.sentence_type      = TYPE_GSV;
         res.satellites_in_view = sentence_acc.field_three_number;
      end else if (sentence_acc.type_seen_flags[FLAG_RMC]) begin
         res.sentence_type        = TYPE_RMC;
         res.fix_time_text        = sentence_acc.field_one_text[63:16];
         res.fix_status_char      = sentence_acc.field_two_char;
         res.latitude_text        = sentence_acc.field_three_text;
         res.latitude_hemisphere  = sentence_acc.field_four_char;
         res.longitude_text       = sentence_acc.field_five_text;
         res.longitude_hemisphere = sentence_acc.field_six_char;
      end else begin
         res.sentence_type = TYPE_NONE;
      end
      sentence_acc = '0;
      return 1'b1;
   endfunction

   // idle length: mostly none or short, now and then long
   function automatic int unsigned draw_gap(input bit calm);
      int unsigned roll;
      if (calm) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      errors++;
      if (errors <= PRINT_LIMIT)
         $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
   endtask

   // queue a sentence, flagging its last character
   task automatic push_sentence(input logic [7:0] chars[$]);
      for (int i = 0; i < chars.size(); i++) begin
         char_backlog.push_back('{code: chars[i], last: (i == chars.size() - 1)});
         chars_queued++;
      end
   endtask

   task automatic push_text(input string s);
      logic [7:0] chars[$];
      for (int i = 0; i < s.len(); i++) chars.push_back(s[i]);
      push_sentence(chars);
   endtask

   // random field body: digits mostly, some letters, dots and arbitrary bytes
   task automatic add_field_body(ref logic [7:0] chars[$]);
      string       pool;
      int unsigned len, roll;
      pool = "NSEWAGLSVRMC";
      roll = $urandom_range(0, 99);
      len = (roll < 20) ? 0 : (roll < 90) ? $urandom_range(1, 9) : $urandom_range(10, 18);
      repeat (len) begin
         roll = $urandom_range(0, 99);
         if (roll < 60) chars.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
         else if (roll < 75) chars.push_back(".");
         else if (roll < 85) chars.push_back(pool[$urandom_range(0, pool.len() - 1)]);
         else chars.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   // random sentence: well-formed with random content, broken, or plain noise
   task automatic add_random_sentence();
      logic [7:0]  chars[$];
      string       tag;
      int unsigned kind, nfields;
      kind = $urandom_range(0, 99);
      if (kind < 80) begin
         chars.push_back("$");
         chars.push_back(8'("A" + $urandom_range(0, 25)));
         chars.push_back(8'("A" + $urandom_range(0, 25)));
         case ($urandom_range(0, 3))
            0: tag = "GLL";
            1: tag = "GSV";
            2: tag = "RMC";
            default: tag = "ZDA";
         endcase
         for (int i = 0; i < tag.len(); i++) chars.push_back(tag[i]);
         nfields = $urandom_range(0, 9);
         repeat (nfields) begin
            chars.push_back(CHAR_COMMA);
            add_field_body(chars);
         end
         // broken sentences: truncated, or a stray byte dropped in
         if (kind >= 65) begin
            if (kind < 73 && chars.size() > 1)
               repeat ($urandom_range(1, chars.size() - 1)) void'(chars.pop_back());
            else
               chars.insert($urandom_range(0, chars.size() - 1), 8'($urandom_range(0, 255)));
         end
      end else begin
         repeat ($urandom_range(1, 24)) begin
            if ($urandom_range(0, 4) == 0) chars.push_back(CHAR_COMMA);
            else chars.push_back(8'($urandom_range(0, 255)));
         end
      end
      push_sentence(chars);
   endtask

   // request driver
   always @(posedge clock) begin : drive_proc
      nmea_char_type item;
      result_type    decoded;
      int unsigned   gap_left;
      int unsigned   drv_cycle;
      drv_cycle++;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            if (fold_char(req_char_code, req_end_of_sentence, decoded))
               awaited_results.push_back(decoded);
            chars_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left != 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (char_backlog.size() != 0) begin
               item = char_backlog.pop_front();
               req_valid           <= 1'b1;
               req_char_code       <= item.code;
               req_end_of_sentence <= item.last;
               gap_left = draw_gap(drv_cycle[8:7] == 2'd0);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and stall generator
   always @(posedge clock) begin : check_proc
      result_type  want;
      int unsigned hold_left;
      int unsigned stall_left;
      int unsigned mon_cycle;
      mon_cycle++;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left  = 0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               report_mismatch("result with none expected", 64'd0, 64'd0);
            end else begin
               want = awaited_results.pop_front();
               if (rsp_sentence_type !== want.sentence_type)
                  report_mismatch("sentence_type", 64'(rsp_sentence_type),
                                  64'(want.sentence_type));
               if (rsp_fix_time_text !== want.fix_time_text)
                  report_mismatch("fix_time_text", 64'(rsp_fix_time_text),
                                  64'(want.fix_time_text));
               if (rsp_fix_status_char !== want.fix_status_char)
                  report_mismatch("fix_status_char", 64'(rsp_fix_status_char),
                                  64'(want.fix_status_char));
               if (rsp_latitude_text !== want.latitude_text)
                  report_mismatch("latitude_text", rsp_latitude_text, want.latitude_text);
               if (rsp_latitude_hemisphere !== want.latitude_hemisphere)
                  report_mismatch("latitude_hemisphere", 64'(rsp_latitude_hemisphere),
                                  64'(want.latitude_hemisphere));
               if (rsp_longitude_text !== want.longitude_text)
                  report_mismatch("longitude_text", rsp_longitude_text, want.longitude_text);
               if (rsp_longitude_hemisphere !== want.longitude_hemisphere)
                  report_mismatch("longitude_hemisphere", 64'(rsp_longitude_hemisphere),
                                  64'(want.longitude_hemisphere));
               if (rsp_satellites_in_view !== want.satellites_in_view)
                  report_mismatch("satellites_in_view", 64'(rsp_satellites_in_view),
                                  64'(want.satellites_in_view));
            end
            results_seen++;
            // long hold-off so the held result backs up the request side
            if (results_seen == 15 || results_seen == 45) hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (stall_left != 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            stall_left = draw_gap(mon_cycle[8:7] == 2'd2);
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus_proc
      logic [7:0]  chars[$];
      int unsigned random_start;

      // directed: each type, priority, absent and overlong fields, number edges
      push_text("$GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4");
      push_text("$GPGLL,4916.45,N,12311.12,W,225444,A");
      push_text("$GPGSV,3,1,11,03,03,111,00");
      push_text("GSV,,,999");
      push_text("GSV,1,2,255");
      push_text("GSV,1,2,256");
      push_text("GSV,,,0");
      push_text("GSV,,,12a34");
      push_text("GSV,,,-5");
      push_text("RMC,1234567890123456789,,,,");
      push_text("GLL,ABCDEFGHIJ,,KLMNOPQRSTUVWXYZ0123,");
      push_text("GLLGSVRMC");
      push_text("$GPXYZ,1,2,3");
      push_text("RMC,a,b,c,d,e,f,g,h,i,j,k");
      push_text("xxRMC");
      push_text(",");
      // a type split across a sentence boundary must not match
      push_text("GL");
      push_text("L,1,2,3,4");
      // arbitrary byte codes, both extremes
      chars = '{8'h00, 8'hFF, "R", "M", "C", CHAR_COMMA, 8'h7F, 8'h80, CHAR_COMMA, 8'hFF};
      push_sentence(chars);
      chars = '{8'hFF};
      push_sentence(chars);
      chars = '{8'h00};
      push_sentence(chars);

      random_start = chars_queued;
      while (chars_queued - random_start < RANDOM_CHARS) add_random_sentence();

      // reset
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // drain: all characters taken, all results back, then the latency pause
      while (chars_accepted != chars_queued) @(posedge clock);
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (errors == 0 && awaited_results.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
